// ===== hdl/wctlv_pkg.sv =====
`default_nettype none

package wctlv_pkg;

    // Entry types of the credential payload.
    localparam logic [15:0] T_CRED   = 16'h100E;
    localparam logic [15:0] T_SSID   = 16'h1045;
    localparam logic [15:0] T_KEY    = 16'h1027;
    localparam logic [15:0] T_AUTH   = 16'h1003;
    localparam logic [15:0] T_VENDOR = 16'h1049;

    // Auth type codes.
    localparam logic [15:0] AUTH_OPEN     = 16'h0001;
    localparam logic [15:0] AUTH_WPA_PSK  = 16'h0002;
    localparam logic [15:0] AUTH_WPA_EAP  = 16'h0008;
    localparam logic [15:0] AUTH_WPA2_EAP = 16'h0010;
    localparam logic [15:0] AUTH_WPA2_PSK = 16'h0020;
    localparam logic [15:0] AUTH_MIXED    = 16'h0022;

    // Key management classes.
    localparam logic [1:0] MG_UNSET = 2'd0;
    localparam logic [1:0] MG_NONE  = 2'd1;
    localparam logic [1:0] MG_PSK   = 2'd2;
    localparam logic [1:0] MG_EAP   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SSID   = 2'd1;
    localparam logic [1:0] KIND_KEY    = 2'd2;
    localparam logic [1:0] KIND_VENDOR = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_BAD_HEADER  = 3'd1;
    localparam logic [2:0] ERR_ZERO_LEN    = 3'd2;
    localparam logic [2:0] ERR_BAD_VALUE   = 3'd3;
    localparam logic [2:0] ERR_KEY_LONG    = 3'd4;
    localparam logic [2:0] ERR_AUTH_LEN    = 3'd5;
    localparam logic [2:0] ERR_AUTH_ZERO   = 3'd6;
    localparam logic [2:0] ERR_KEY_MISSING = 3'd7;

    // Register indexes of the configuration port.
    localparam logic REG_MAX_VALUE_LEN = 1'b0;
    localparam logic REG_MAX_KEY_LEN   = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       first_of_value;
        logic       valid_res;
        logic [1:0] key_mgmt;
        logic       key_dropped;
        logic [2:0] error_code;
        logic       is_final;
    } t_result;

    function automatic logic [1:0] kind_of(input logic [15:0] etype);
        logic [1:0] k;
        if (etype == T_SSID) begin
            k = KIND_SSID;
        end else if (etype == T_KEY) begin
            k = KIND_KEY;
        end else begin
            k = KIND_VENDOR;
        end
        return k;
    endfunction

    // Unknown nonzero auth types leave the class as it was.
    function automatic logic [1:0] map_auth(input logic [15:0] a, input logic [1:0] cur);
        logic [1:0] m;
        m = cur;
        if (a == AUTH_OPEN) begin
            m = MG_NONE;
        end else if (a == AUTH_WPA_PSK || a == AUTH_WPA2_PSK || a == AUTH_MIXED) begin
            m = MG_PSK;
        end else if (a == AUTH_WPA_EAP || a == AUTH_WPA2_EAP) begin
            m = MG_EAP;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wifi_credential_tlv_parser.sv =====
`default_nettype none

// Channel   Dir  tdata                                       tuser   tlast
// s_axis    in   [7:0] byte_in                               -       is_last
// m_axis    out  [7:0] data_byte, [8] first_of_value,        kind    is_final
//                [9] valid_res, [11:10] key_mgmt,
//                [12] key_dropped, [15:13] error_code
// cfg       in   i_cfg_addr 0 max_value_len, 1 max_key_len; i_cfg_wdata 16 bit
//
// One input item per cycle. Each item is parsed in the cycle it is accepted and its
// zero, one or two results land in a four-entry result queue, visible from the next
// cycle and drained one item per cycle; a value byte that is also the last gives two.
// s_axis_tready is high while the queue holds at most two results, so the input
// stalls only while the receiver holds results back.
// Reset is synchronous, active low, and clears the parser state, the queue and
// the registers to 2000 and 64.

module wifi_credential_tlv_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] byte_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,    // [7:0] data_byte, [8] first_of_value,
                                              // [9] valid_res, [11:10] key_mgmt,
                                              // [12] key_dropped, [15:13] error_code
    output logic [1:0]       m_axis_tuser,    // [1:0] kind
    output logic             m_axis_tlast
);
    import wctlv_pkg::*;

    localparam logic [2:0] PH_HDR_TYPE = 3'd0;
    localparam logic [2:0] PH_HDR_LEN  = 3'd1;
    localparam logic [2:0] PH_ENT_TYPE = 3'd2;
    localparam logic [2:0] PH_ENT_LEN  = 3'd3;
    localparam logic [2:0] PH_VALUE    = 3'd4;
    localparam logic [2:0] PH_AUTH     = 3'd5;
    localparam logic [2:0] PH_SKIP     = 3'd6;
    localparam logic [2:0] PH_HALT     = 3'd7;

    logic [15:0] r_max_value_len;
    logic [15:0] r_max_key_len;

    logic [2:0]  r_phase,        n_phase;
    logic        r_hdr_cnt,      n_hdr_cnt;
    logic [15:0] r_entry_type,   n_entry_type;
    logic [15:0] r_entry_len,    n_entry_len;
    logic [15:0] r_remain,       n_remain;
    logic [7:0]  r_auth_hi,      n_auth_hi;
    logic [2:0]  r_err,          n_err;
    logic [1:0]  r_mgmt,         n_mgmt;
    logic        r_ssid_seen,    n_ssid_seen;
    logic        r_key_seen,     n_key_seen;

    t_result     r_queue [4];
    logic [1:0]  r_wr_ptr;
    logic [1:0]  r_rd_ptr;
    logic [2:0]  r_count;

    logic        in_acc;
    logic        out_acc;
    t_result     res_a;
    t_result     res_b;
    logic [1:0]  push_n;
    t_result     head;

    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (r_count <= 3'd2);
    assign m_axis_tvalid = (r_count != 3'd0);
    assign out_acc       = m_axis_tvalid & m_axis_tready;

    assign head          = r_queue[r_rd_ptr];
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.is_final;
    assign m_axis_tdata  = {head.error_code, head.key_dropped, head.key_mgmt,
                            head.valid_res, head.first_of_value, head.data_byte};

    always_comb begin
        logic [7:0]  b;
        logic [15:0] v16;
        logic        val_out;
        t_result     vres;
        t_result     sres;
        logic [2:0]  ferr;
        logic        fdrop;

        b            = s_axis_tdata;
        v16          = 16'd0;
        val_out      = 1'b0;
        vres         = '0;
        sres         = '0;
        ferr         = ERR_OK;
        fdrop        = 1'b0;

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_entry_type = r_entry_type;
        n_entry_len  = r_entry_len;
        n_remain     = r_remain;
        n_auth_hi    = r_auth_hi;
        n_err        = r_err;
        n_mgmt       = r_mgmt;
        n_ssid_seen  = r_ssid_seen;
        n_key_seen   = r_key_seen;

        res_a  = '0;
        res_b  = '0;
        push_n = 2'd0;

        if (in_acc) begin
            unique case (r_phase)
                PH_HDR_TYPE: begin
                    if (!r_hdr_cnt) begin
                        n_entry_type = {b, 8'h00};
                        n_hdr_cnt    = 1'b1;
                    end else begin
                        n_entry_type = {r_entry_type[15:8], b};
                        n_hdr_cnt    = 1'b0;
                        if ({r_entry_type[15:8], b} != T_CRED) begin
                            n_err   = ERR_BAD_HEADER;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_HDR_LEN;
                        end
                    end
                end
                PH_HDR_LEN: begin
                    if (!r_hdr_cnt) begin
                        n_entry_len = {b, 8'h00};
                        n_hdr_cnt   = 1'b1;
                    end else begin
                        n_entry_len = {r_entry_len[15:8], b};
                        n_hdr_cnt   = 1'b0;
                        if ({r_entry_len[15:8], b} == 16'd0) begin
                            n_err   = ERR_ZERO_LEN;
                            n_phase = PH_HALT;
                        end else begin
                            n_phase = PH_ENT_TYPE;
                        end
                    end
                end
                PH_ENT_TYPE: begin
                    if (!r_hdr_cnt) begin
                        n_entry_type = {b, 8'h00};
                        n_hdr_cnt    = 1'b1;
                    end else begin
                        n_entry_type = {r_entry_type[15:8], b};
                        n_hdr_cnt    = 1'b0;
                        n_phase      = PH_ENT_LEN;
                    end
                end
                PH_ENT_LEN: begin
                    if (!r_hdr_cnt) begin
                        n_entry_len = {b, 8'h00};
                        n_hdr_cnt   = 1'b1;
                    end else begin
                        v16         = {r_entry_len[15:8], b};
                        n_entry_len = v16;
                        n_hdr_cnt   = 1'b0;
                        if (r_entry_type == T_SSID || r_entry_type == T_KEY ||
                            r_entry_type == T_VENDOR) begin
                            // The key limit is checked before the general one.
                            if (r_entry_type == T_KEY && v16 > r_max_key_len) begin
                                n_err   = ERR_KEY_LONG;
                                n_phase = PH_HALT;
                            end else if (v16 == 16'd0 || v16 > r_max_value_len) begin
                                n_err   = ERR_BAD_VALUE;
                                n_phase = PH_HALT;
                            end else begin
                                if (r_entry_type == T_SSID) begin
                                    n_ssid_seen = 1'b1;
                                end
                                if (r_entry_type == T_KEY) begin
                                    n_key_seen = 1'b1;
                                end
                                n_remain = v16;
                                n_phase  = PH_VALUE;
                            end
                        end else if (r_entry_type == T_AUTH) begin
                            if (v16 != 16'd2) begin
                                n_err   = ERR_AUTH_LEN;
                                n_phase = PH_HALT;
                            end else begin
                                n_phase = PH_AUTH;
                            end
                        end else begin
                            n_remain = v16;
                            n_phase  = (v16 == 16'd0) ? PH_ENT_TYPE : PH_SKIP;
                        end
                    end
                end
                PH_VALUE: begin
                    val_out             = 1'b1;
                    vres.kind           = kind_of(r_entry_type);
                    vres.data_byte      = b;
                    vres.first_of_value = (r_remain == r_entry_len);
                    n_remain            = r_remain - 16'd1;
                    if (r_remain == 16'd1) begin
                        n_phase = PH_ENT_TYPE;
                    end
                end
                PH_AUTH: begin
                    if (!r_hdr_cnt) begin
                        n_auth_hi = b;
                        n_hdr_cnt = 1'b1;
                    end else begin
                        n_hdr_cnt = 1'b0;
                        v16       = {r_auth_hi, b};
                        if (v16 == 16'd0) begin
                            n_err   = ERR_AUTH_ZERO;
                            n_phase = PH_HALT;
                        end else begin
                            n_mgmt  = map_auth(v16, r_mgmt);
                            n_phase = PH_ENT_TYPE;
                        end
                    end
                end
                PH_SKIP: begin
                    n_remain = r_remain - 16'd1;
                    if (r_remain == 16'd1) begin
                        n_phase = PH_ENT_TYPE;
                    end
                end
                default: begin
                end
            endcase

            if (s_axis_tlast) begin
                // Final status comes from the state this byte leaves behind.
                ferr = n_err;
                unique case (n_phase)
                    PH_HDR_TYPE: ferr = ERR_BAD_HEADER;
                    PH_HDR_LEN:  ferr = ERR_ZERO_LEN;
                    PH_ENT_LEN: begin
                        if (n_entry_type == T_SSID || n_entry_type == T_KEY ||
                            n_entry_type == T_VENDOR) begin
                            ferr = ERR_BAD_VALUE;
                        end else if (n_entry_type == T_AUTH) begin
                            ferr = ERR_AUTH_LEN;
                        end
                    end
                    PH_VALUE:    ferr = ERR_BAD_VALUE;
                    PH_AUTH:     ferr = ERR_AUTH_ZERO;
                    default: begin
                    end
                endcase
                if (ferr == ERR_OK && n_ssid_seen) begin
                    if (n_mgmt == MG_NONE) begin
                        fdrop = n_key_seen;
                    end else if (!n_key_seen) begin
                        ferr = ERR_KEY_MISSING;
                    end
                end
                sres.kind        = KIND_STATUS;
                sres.valid_res   = (ferr == ERR_OK);
                sres.key_mgmt    = (ferr == ERR_OK) ? n_mgmt : MG_UNSET;
                sres.key_dropped = (ferr == ERR_OK) ? fdrop : 1'b0;
                sres.error_code  = ferr;
                sres.is_final    = 1'b1;

                n_phase      = PH_HDR_TYPE;
                n_hdr_cnt    = 1'b0;
                n_entry_type = 16'd0;
                n_entry_len  = 16'd0;
                n_remain     = 16'd0;
                n_auth_hi    = 8'd0;
                n_err        = ERR_OK;
                n_mgmt       = MG_UNSET;
                n_ssid_seen  = 1'b0;
                n_key_seen   = 1'b0;
            end

            if (val_out) begin
                res_a  = vres;
                res_b  = sres;
                push_n = s_axis_tlast ? 2'd2 : 2'd1;
            end else if (s_axis_tlast) begin
                res_a  = sres;
                push_n = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value_len <= 16'd2000;
            r_max_key_len   <= 16'd64;
            r_phase         <= PH_HDR_TYPE;
            r_hdr_cnt       <= 1'b0;
            r_entry_type    <= 16'd0;
            r_entry_len     <= 16'd0;
            r_remain        <= 16'd0;
            r_auth_hi       <= 8'd0;
            r_err           <= ERR_OK;
            r_mgmt          <= MG_UNSET;
            r_ssid_seen     <= 1'b0;
            r_key_seen      <= 1'b0;
            r_wr_ptr        <= 2'd0;
            r_rd_ptr        <= 2'd0;
            r_count         <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_MAX_VALUE_LEN: r_max_value_len <= i_cfg_wdata;
                    REG_MAX_KEY_LEN:   r_max_key_len   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_entry_type <= n_entry_type;
            r_entry_len  <= n_entry_len;
            r_remain     <= n_remain;
            r_auth_hi    <= n_auth_hi;
            r_err        <= n_err;
            r_mgmt       <= n_mgmt;
            r_ssid_seen  <= n_ssid_seen;
            r_key_seen   <= n_key_seen;
            r_wr_ptr     <= r_wr_ptr + push_n;
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {1'b0, push_n} - {2'b00, out_acc};
        end
    end

    // Result queue storage; payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= res_a;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= res_b;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue count out of range");

    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_STATUS)
        else $error("final result with a byte kind");

    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tlast |=> r_phase == PH_HDR_TYPE && r_err == ERR_OK
            && !r_hdr_cnt)
        else $error("parser state not cleared after last byte");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> head.valid_res == (head.error_code == ERR_OK))
        else $error("status valid flag disagrees with error code");
`endif

endmodule

`default_nettype wire

// ===== dv/wifi_credential_tlv_parser_tb.sv =====
module wifi_credential_tlv_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wctlv_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_BYTES   = 110;
    localparam int N_SETTINGS    = 8;
    localparam int N_DIRECTED    = 28;
    localparam int MAX_REPORTED  = 40;

    typedef enum logic [2:0] {
        ST_CRED_TYPE,
        ST_CRED_LEN,
        ST_TAG,
        ST_LEN,
        ST_VALUE,
        ST_AUTH,
        ST_SKIP,
        ST_HALTED
    } t_parse_state;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic [2:0] err;
        logic [1:0] mgmt;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = REG_MAX_VALUE_LEN;
    logic [15:0] i_cfg_wdata   = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] byte_in
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] data_byte, [8] first_of_value,
                                           // [9] valid_res, [11:10] key_mgmt,
                                           // [12] key_dropped, [15:13] error_code
    logic [1:0]  m_axis_tuser;             // [1:0] kind
    logic        m_axis_tlast;

    // Parser state mirrored by the predictor.
    t_parse_state pr_state;
    logic         pr_half;
    logic [15:0]  pr_tag;
    logic [15:0]  pr_len;
    logic [15:0]  pr_left;
    logic [7:0]   pr_auth_hi;
    logic [2:0]   pr_err;
    logic [1:0]   pr_mgmt;
    logic         pr_ssid;
    logic         pr_key;
    logic [15:0]  lim_value;
    logic [15:0]  lim_key;

    t_result     tlv_results_due[$];
    logic [7:0]  payload[$];
    t_stim_row   directed_rows[N_DIRECTED];
    logic [15:0] cfg_value_len[N_SETTINGS];
    logic [15:0] cfg_key_len[N_SETTINGS];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int mismatches    = 0;
    int n_bytes       = 0;
    int n_payloads    = 0;
    int n_checked     = 0;
    int n_status      = 0;
    int n_accepted    = 0;
    int quiet_cycles  = 0;

    wifi_credential_tlv_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic clear_run();
        pr_state   = ST_CRED_TYPE;
        pr_half    = 1'b0;
        pr_tag     = 16'h0000;
        pr_len     = 16'h0000;
        pr_left    = 16'h0000;
        pr_auth_hi = 8'h00;
        pr_err     = ERR_OK;
        pr_mgmt    = MG_UNSET;
        pr_ssid    = 1'b0;
        pr_key     = 1'b0;
    endtask

    task automatic halt_with(input logic [2:0] code);
        pr_err   = code;
        pr_state = ST_HALTED;
    endtask

    // Big-endian 16-bit field, one byte at a time; done goes high on the low byte.
    task automatic take_half(inout logic [15:0] dst, input logic [7:0] b, output logic done);
        if (!pr_half) begin
            dst     = {b, 8'h00};
            pr_half = 1'b1;
            done    = 1'b0;
        end else begin
            dst     = dst | {8'h00, b};
            pr_half = 1'b0;
            done    = 1'b1;
        end
    endtask

    task automatic parse_tlv_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic        done;
        logic        streamed;
        logic [15:0] word;
        logic [2:0]  err;
        logic        dropped;
        streamed = (pr_tag == T_SSID) || (pr_tag == T_KEY) || (pr_tag == T_VENDOR);
        case (pr_state)
            ST_CRED_TYPE: begin
                take_half(pr_tag, b, done);
                if (done) begin
                    if (pr_tag != T_CRED) halt_with(ERR_BAD_HEADER);
                    else pr_state = ST_CRED_LEN;
                end
            end
            ST_CRED_LEN: begin
                take_half(pr_len, b, done);
                if (done) begin
                    if (pr_len == 16'h0000) halt_with(ERR_ZERO_LEN);
                    else pr_state = ST_TAG;
                end
            end
            ST_TAG: begin
                take_half(pr_tag, b, done);
                if (done) pr_state = ST_LEN;
            end
            ST_LEN: begin
                take_half(pr_len, b, done);
                if (done) begin
                    if (streamed) begin
                        // The key length limit is checked ahead of the general one.
                        if (pr_tag == T_KEY && pr_len > lim_key) begin
                            halt_with(ERR_KEY_LONG);
                        end else if (pr_len == 16'h0000 || pr_len > lim_value) begin
                            halt_with(ERR_BAD_VALUE);
                        end else begin
                            if (pr_tag == T_SSID) pr_ssid = 1'b1;
                            if (pr_tag == T_KEY) pr_key = 1'b1;
                            pr_left  = pr_len;
                            pr_state = ST_VALUE;
                        end
                    end else if (pr_tag == T_AUTH) begin
                        if (pr_len != 16'd2) halt_with(ERR_AUTH_LEN);
                        else pr_state = ST_AUTH;
                    end else begin
                        pr_left  = pr_len;
                        pr_state = (pr_len == 16'h0000) ? ST_TAG : ST_SKIP;
                    end
                end
            end
            ST_VALUE: begin
                r = '0;
                r.kind = (pr_tag == T_SSID) ? KIND_SSID :
                         (pr_tag == T_KEY) ? KIND_KEY : KIND_VENDOR;
                r.data_byte      = b;
                r.first_of_value = (pr_left == pr_len);
                tlv_results_due.push_back(r);
                pr_left = pr_left - 16'd1;
                if (pr_left == 16'h0000) pr_state = ST_TAG;
            end
            ST_AUTH: begin
                if (!pr_half) begin
                    pr_auth_hi = b;
                    pr_half    = 1'b1;
                end else begin
                    pr_half = 1'b0;
                    word    = {pr_auth_hi, b};
                    if (word == 16'h0000) begin
                        halt_with(ERR_AUTH_ZERO);
                    end else begin
                        // Unknown auth types keep whatever class was set before.
                        case (word)
                            AUTH_OPEN:                              pr_mgmt = MG_NONE;
                            AUTH_WPA_PSK, AUTH_WPA2_PSK, AUTH_MIXED: pr_mgmt = MG_PSK;
                            AUTH_WPA_EAP, AUTH_WPA2_EAP:            pr_mgmt = MG_EAP;
                            default: ;
                        endcase
                        pr_state = ST_TAG;
                    end
                end
            end
            ST_SKIP: begin
                pr_left = pr_left - 16'd1;
                if (pr_left == 16'h0000) pr_state = ST_TAG;
            end
            default: ;
        endcase

        if (last) begin
            err     = pr_err;
            dropped = 1'b0;
            case (pr_state)
                ST_CRED_TYPE: err = ERR_BAD_HEADER;
                ST_CRED_LEN:  err = ERR_ZERO_LEN;
                // A cut-off entry header with a complete type reads as length zero.
                // The type may have been completed by this very byte.
                ST_LEN: begin
                    if ((pr_tag == T_SSID) || (pr_tag == T_KEY) || (pr_tag == T_VENDOR))
                        err = ERR_BAD_VALUE;
                    else if (pr_tag == T_AUTH) err = ERR_AUTH_LEN;
                end
                ST_VALUE: err = ERR_BAD_VALUE;
                ST_AUTH:  err = ERR_AUTH_ZERO;
                default: ;
            endcase
            if (err == ERR_OK && pr_ssid) begin
                if (pr_mgmt == MG_NONE) dropped = pr_key;
                else if (!pr_key) err = ERR_KEY_MISSING;
            end
            r = '0;
            r.kind        = KIND_STATUS;
            r.valid_res   = (err == ERR_OK);
            r.key_mgmt    = (err == ERR_OK) ? pr_mgmt : MG_UNSET;
            r.key_dropped = (err == ERR_OK) ? dropped : 1'b0;
            r.error_code  = err;
            r.is_final    = 1'b1;
            tlv_results_due.push_back(r);
            clear_run();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_tlv_byte(b, last);
        n_bytes++;
    endtask

    // Drops valid, waits for every predicted result and lets the parser settle.
    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tlv_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [15:0] value_len, input logic [15:0] key_len);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MAX_VALUE_LEN;
        i_cfg_wdata <= value_len;
        @(negedge i_clk);
        i_cfg_addr  <= REG_MAX_KEY_LEN;
        i_cfg_wdata <= key_len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_value = value_len;
        lim_key   = key_len;
    endtask

    task automatic push_word(input logic [15:0] w);
        payload.push_back(w[15:8]);
        payload.push_back(w[7:0]);
    endtask

    // Mostly well-formed credentials with random entries; some noise and cut-off runs.
    task automatic build_payload();
        int          n;
        int          sel;
        logic [15:0] tag;
        logic [15:0] len;
        logic [15:0] auth;
        payload.delete();
        if ($urandom_range(99) < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) payload.push_back(8'($urandom_range(255)));
        end else begin
            tag = ($urandom_range(19) == 0) ? 16'($urandom) : T_CRED;
            len = ($urandom_range(19) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'hFFFF));
            push_word(tag);
            push_word(len);
            n = $urandom_range(0, 5);
            for (int e = 0; e < n; e++) begin
                case ($urandom_range(9))
                    0, 1:    tag = T_SSID;
                    2, 3:    tag = T_KEY;
                    4:       tag = T_VENDOR;
                    5, 6:    tag = T_AUTH;
                    default: tag = 16'($urandom);
                endcase
                if (tag == T_AUTH && $urandom_range(9) != 0) begin
                    len = 16'd2;
                end else begin
                    sel = $urandom_range(19);
                    if (sel == 0) len = 16'h0000;
                    else if (sel == 1) len = 16'($urandom);
                    else len = 16'($urandom_range(1, 6));
                end
                push_word(tag);
                push_word(len);
                if (tag == T_AUTH && len == 16'd2) begin
                    case ($urandom_range(7))
                        0:       auth = AUTH_OPEN;
                        1:       auth = AUTH_WPA_PSK;
                        2:       auth = AUTH_WPA_EAP;
                        3:       auth = AUTH_WPA2_EAP;
                        4:       auth = AUTH_WPA2_PSK;
                        5:       auth = AUTH_MIXED;
                        6:       auth = 16'h0000;
                        default: auth = 16'($urandom);
                    endcase
                    push_word(auth);
                end else if (len > 16'd8) begin
                    // Long values are only started; the run ends inside them.
                    repeat ($urandom_range(0, 3)) payload.push_back(8'($urandom_range(255)));
                    break;
                end else begin
                    repeat (len) payload.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(9) == 0) begin
                payload = payload[0:$urandom_range(0, payload.size() - 2)];
            end
        end
    endtask

    task automatic flag_mismatch(input string field, input int got, input int want);
        if (mismatches < MAX_REPORTED) begin
            $display("%0t ns: %s mismatch on result %0d: got 0x%0h, expected 0x%0h",
                     $time, field, n_checked, got, want);
        end
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tlv_results_due.size() == 0) begin
                flag_mismatch("unexpected result, tdata", int'(m_axis_tdata), 0);
            end else begin
                want = tlv_results_due.pop_front();
                if (m_axis_tuser != want.kind)
                    flag_mismatch("kind", int'(m_axis_tuser), int'(want.kind));
                if (m_axis_tdata[7:0] != want.data_byte)
                    flag_mismatch("data_byte", int'(m_axis_tdata[7:0]),
                                  int'(want.data_byte));
                if (m_axis_tdata[8] != want.first_of_value)
                    flag_mismatch("first_of_value", int'(m_axis_tdata[8]),
                                  int'(want.first_of_value));
                if (m_axis_tdata[9] != want.valid_res)
                    flag_mismatch("valid_res", int'(m_axis_tdata[9]), int'(want.valid_res));
                if (m_axis_tdata[11:10] != want.key_mgmt)
                    flag_mismatch("key_mgmt", int'(m_axis_tdata[11:10]), int'(want.key_mgmt));
                if (m_axis_tdata[12] != want.key_dropped)
                    flag_mismatch("key_dropped", int'(m_axis_tdata[12]),
                                  int'(want.key_dropped));
                if (m_axis_tdata[15:13] != want.error_code)
                    flag_mismatch("error_code", int'(m_axis_tdata[15:13]),
                                  int'(want.error_code));
                if (m_axis_tlast != want.is_final)
                    flag_mismatch("is_final", int'(m_axis_tlast), int'(want.is_final));
                if (want.is_final) begin
                    n_status++;
                    if (want.valid_res) n_accepted++;
                end
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("wifi_credential_tlv_parser_tb failed");
            $finish;
        end
    end

    initial begin
        t_result status;
        directed_rows = '{
            '{8'hFF, 1'b1, 1'b1, ERR_BAD_HEADER, MG_UNSET},
            // Run ends inside the credential length.
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h0E, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b1, 1'b1, ERR_ZERO_LEN, MG_UNSET},
            // Credential length of zero.
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h0E, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b1, 1'b1, ERR_ZERO_LEN, MG_UNSET},
            // SSID, WPA2-PSK auth and a key: a complete good credential.
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h0E, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h01, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h45, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h01, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h41, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h03, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h02, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h20, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h10, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h27, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h00, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'h01, 1'b0, 1'b0, ERR_OK, MG_UNSET},
            '{8'hFF, 1'b1, 1'b1, ERR_OK, MG_PSK}
        };
        cfg_value_len = '{16'd2000, 16'd5, 16'd0, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0, 16'd2000};
        cfg_key_len   = '{16'd64, 16'd3, 16'hFFFF, 16'd0, 16'hFFFF, 16'd6, 16'd0, 16'd64};
        cfg_value_len[6] = 16'($urandom_range(1, 12));
        cfg_key_len[6]   = 16'($urandom_range(1, 12));

        lim_value = 16'd2000;
        lim_key   = 16'd64;
        clear_run();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(directed_rows[i].b, directed_rows[i].last);
            if (directed_rows[i].typed) begin
                status = '0;
                status.kind       = KIND_STATUS;
                status.valid_res  = (directed_rows[i].err == ERR_OK);
                status.key_mgmt   = directed_rows[i].mgmt;
                status.error_code = directed_rows[i].err;
                status.is_final   = 1'b1;
                tlv_results_due[tlv_results_due.size() - 1] = status;
            end
        end

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain_and_settle();
            if (p != 0) write_limits(cfg_value_len[p], cfg_key_len[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            for (int start = n_bytes; n_bytes - start < PHASE_BYTES; ) begin
                build_payload();
                for (int i = 0; i < payload.size(); i++) begin
                    send_byte(payload[i], i == payload.size() - 1);
                end
                n_payloads++;
            end
        end
        drain_and_settle();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d input bytes in %0d random credentials under %0d limit settings.",
                 n_bytes, n_payloads, N_SETTINGS);
        $display("Checked %0d results: %0d final statuses, %0d accepted; %0d mismatches.",
                 n_checked, n_status, n_accepted, mismatches);
        if (mismatches == 0) begin
            $display("wifi_credential_tlv_parser_tb passed");
        end else begin
            $display("wifi_credential_tlv_parser_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/wctlv_pkg.sv
hdl/wifi_credential_tlv_parser.sv
dv/wifi_credential_tlv_parser_tb.sv
